// File: rtl/bbscf_pkg.sv
package bbscf_pkg;

	// Storage geometry.
	localparam int DEPTH  = 4096;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = $clog2(DEPTH + 1);
	localparam int CNT_W  = $clog2(DEPTH * 8 + 1);
	localparam int POS_W  = ADDR_W + 3;
	localparam int RES_W  = 17;

	// Operation codes carried by a request.
	localparam logic [2:0] OP_SET   = 3'd0;
	localparam logic [2:0] OP_GET   = 3'd1;
	localparam logic [2:0] OP_COUNT = 3'd2;
	localparam logic [2:0] OP_POS   = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANGE,
		ST_WALK,
		ST_DRAIN,
		ST_READ,
		ST_MODIFY,
		ST_PAD,
		ST_RESP
	} state_t;

	// Controls from the sequencer to the byte scanner.
	typedef struct packed {
		logic              start;
		logic              find_mode;
		logic              want;
		logic              byte_valid;
		logic [ADDR_W-1:0] byte_idx;
	} scan_ctrl_t;

	// Running results of the byte scanner.
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
	} scan_stat_t;

	// Number of one bits in a byte.
	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] c;
		c = '0;
		for (int j = 0; j < 8; j++) begin
			c = c + 4'(v[j]);
		end
		return c;
	endfunction

endpackage

// File: rtl/bbscf_ram.sv
module bbscf_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/bbscf_scan.sv
module bbscf_scan
	import bbscf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  scan_ctrl_t ctrl,
	input  logic [7:0] byte_data,
	output scan_stat_t stat
);

	logic [CNT_W-1:0] count_q;
	logic             found_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       match;
	logic [2:0]       lead;

	// Find the first wanted bit in the byte, most significant bit first.
	always_comb begin
		match = ctrl.want ? byte_data : ~byte_data;
		lead  = '0;
		for (int j = 0; j < 8; j++) begin
			if (match[j]) begin
				lead = 3'(7 - j);
			end
		end
	end

	// Accumulate the count and keep the first hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else if (ctrl.start) begin
			count_q <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else if (ctrl.byte_valid) begin
			count_q <= count_q + CNT_W'(popcount8(byte_data));
			if (ctrl.find_mode && !found_q && (|match)) begin
				found_q <= 1'b1;
				pos_q   <= {ctrl.byte_idx, lead};
			end
		end
	end

	assign stat.count = count_q;
	assign stat.found = found_q;
	assign stat.pos   = pos_q;

endmodule

// File: rtl/bitmap_bit_set_count_find_unit.sv
// A set or get inside the string goes through read, modify and response states; a set that
// grows the string pads with one byte per cycle, from the old end up to the target byte.
// Bit count and bit position read one byte per cycle from the byte memory over the range,
// and bit position stops early at the first match. One request is in work at a time.
// Reset sets the string length to zero; the byte memory is not cleared and needs no sweep.
module bitmap_bit_set_count_find_unit
	import bbscf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              operation,
	input  logic [31:0]             bit_index,
	input  logic                    bit_value,
	input  logic                    use_range,
	input  logic signed [31:0]      range_start,
	input  logic signed [31:0]      range_end,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [RES_W-1:0] result_value,
	output logic                    status
);

	state_t state_q, state_nxt;

	logic [2:0]              op_q;
	logic [ADDR_W-1:0]       byte_q;
	logic [2:0]              bitsel_q;
	logic                    bval_q;
	logic                    ranged_q;
	logic signed [31:0]      rs_q;
	logic signed [31:0]      re_q;
	logic [LEN_W-1:0]        len_q;
	logic [ADDR_W-1:0]       hi_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [RES_W-1:0]        res_q;
	logic                    status_q;
	logic                    rd_pend_s1;
	logic [ADDR_W-1:0]       rd_idx_s1;
	logic                    out_valid_q;
	logic [RES_W-1:0]        result_value_q;
	logic                    out_status_q;

	logic                    accept;
	logic                    over;
	logic                    in_len;
	logic                    resp_fire;
	logic [7:0]              mask;
	logic [RES_W-1:0]        final_value;

	logic signed [33:0]      len_x, rs_x, re_x, s0, e0, s1, e1;
	logic                    skip_neg;
	logic                    range_empty;

	logic                    rd_en, wr_en;
	logic [ADDR_W-1:0]       rd_addr, wr_addr;
	logic [7:0]              rd_data, wr_data;
	scan_ctrl_t              scan_ctrl;
	scan_stat_t              scan_stat;

	// Byte storage and the scanner that walks it.
	bbscf_ram #(.ADDR_W(ADDR_W), .DATA_W(8)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bbscf_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (scan_ctrl),
		.byte_data (rd_data),
		.stat      (scan_stat)
	);

	// Request decode at the accept edge.
	assign accept    = in_valid && !in_stall;
	assign over      = (bit_index >> 3) >= 32'(DEPTH);
	assign in_len    = !over && (LEN_W'(bit_index[ADDR_W+2:3]) < len_q);
	assign resp_fire = (state_q == ST_RESP) && (!out_valid_q || !out_stall);
	assign mask      = 8'h80 >> bitsel_q;

	// Convert and clamp the byte range against the current length.
	always_comb begin
		len_x    = signed'(34'(len_q));
		rs_x     = ranged_q ? 34'(rs_q) : '0;
		if (ranged_q) begin
			re_x = 34'(re_q);
		end else if (op_q == OP_COUNT) begin
			re_x = len_x - 34'sd1;
		end else begin
			re_x = -34'sd1;
		end
		skip_neg = (op_q == OP_COUNT) && ranged_q && (rs_q < 0) && (re_q < 0) && (rs_q > re_q);
		s0 = (rs_x < 0) ? rs_x + len_x : rs_x;
		e0 = (re_x < 0) ? re_x + len_x : re_x;
		s1 = (s0 < 0) ? '0 : s0;
		e1 = (e0 < 0) ? '0 : e0;
		if (e1 >= len_x) begin
			e1 = len_x - 34'sd1;
		end
		range_empty = skip_neg || (len_q == '0) || (s1 > e1);
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (operation)
						OP_SET:   state_nxt = over ? ST_RESP : (in_len ? ST_READ : ST_PAD);
						OP_GET:   state_nxt = in_len ? ST_READ : ST_RESP;
						OP_COUNT: state_nxt = ST_RANGE;
						OP_POS:   state_nxt = ST_RANGE;
						default:  state_nxt = ST_RESP;
					endcase
				end
			end
			ST_RANGE:  state_nxt = range_empty ? ST_RESP : ST_WALK;
			ST_WALK: begin
				if (scan_stat.found) begin
					state_nxt = ST_RESP;
				end else if (addr_q == hi_q) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_nxt = ST_RESP;
			ST_READ:   state_nxt = ST_MODIFY;
			ST_MODIFY: state_nxt = ST_RESP;
			ST_PAD:    state_nxt = (addr_q == byte_q) ? ST_RESP : ST_PAD;
			ST_RESP:   state_nxt = resp_fire ? ST_IDLE : ST_RESP;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Memory, scanner and handshake controls.
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		rd_en    = (state_q == ST_READ) || (state_q == ST_WALK);
		rd_addr  = (state_q == ST_WALK) ? addr_q : byte_q;
		wr_en    = ((state_q == ST_MODIFY) && (op_q == OP_SET)) || (state_q == ST_PAD);
		wr_addr  = (state_q == ST_PAD) ? addr_q : byte_q;
		wr_data  = (rd_data & ~mask) | (mask & {8{bval_q}});
		if (state_q == ST_PAD) begin
			wr_data = (addr_q == byte_q) ? (mask & {8{bval_q}}) : '0;
		end
		scan_ctrl.start      = (state_q == ST_RANGE);
		scan_ctrl.find_mode  = (op_q == OP_POS);
		scan_ctrl.want       = bval_q;
		scan_ctrl.byte_valid = rd_pend_s1;
		scan_ctrl.byte_idx   = rd_idx_s1;
	end

	// Pick the result of the finished request.
	always_comb begin
		case (op_q)
			OP_COUNT: final_value = RES_W'(scan_stat.count);
			OP_POS:   final_value = scan_stat.found ? RES_W'(scan_stat.pos) : '1;
			default:  final_value = res_q;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			rd_pend_s1 <= (state_q == ST_WALK);
			if (accept && (operation == OP_CLEAR)) begin
				len_q <= '0;
			end
			if ((state_q == ST_PAD) && (addr_q == byte_q)) begin
				len_q <= LEN_W'(byte_q) + LEN_W'(1);
			end
		end
	end

	// Request fields, walk address and working result.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (accept) begin
			op_q     <= operation;
			byte_q   <= bit_index[ADDR_W+2:3];
			bitsel_q <= bit_index[2:0];
			bval_q   <= bit_value;
			ranged_q <= use_range;
			rs_q     <= range_start;
			re_q     <= range_end;
			addr_q   <= len_q[ADDR_W-1:0];
			res_q    <= '0;
			status_q <= (operation == OP_SET) && over;
		end
		case (state_q)
			ST_RANGE: begin
				addr_q <= s1[ADDR_W-1:0];
				hi_q   <= e1[ADDR_W-1:0];
			end
			ST_WALK:   addr_q <= addr_q + ADDR_W'(1);
			ST_PAD: begin
				if (addr_q != byte_q) begin
					addr_q <= addr_q + ADDR_W'(1);
				end
			end
			ST_MODIFY: res_q <= RES_W'((rd_data & mask) != '0);
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_fire) begin
			result_value_q <= final_value;
			out_status_q   <= status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = signed'(result_value_q);
	assign status       = out_status_q;

	// The length never passes the capacity.
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(DEPTH))
		else $error("string length beyond capacity");

	// The walk address stays within the clamped range end.
	a_walk_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (addr_q <= hi_q))
		else $error("walk address passed range end");

	// A successful set leaves the target byte inside the string.
	a_set_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) && (op_q == OP_SET) && !status_q |-> (len_q > LEN_W'(byte_q)))
		else $error("set did not cover its byte");

	// Read data in flight only while a walk finishes.
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> ((state_q == ST_WALK) || (state_q == ST_DRAIN) || (state_q == ST_RESP)))
		else $error("scan byte outside a walk");

endmodule
